>>> hdl/ifg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifg_pkg
// Shared types, constants and fixed-point helpers of the fling glide engine.
// ----------------------------------------------------------------------------
package ifg_pkg;

	localparam int FINGER_COUNT  = 10;
	localparam int FRACTION_BITS = 8;

	localparam int ADDR_W = (FINGER_COUNT > 1) ? $clog2(FINGER_COUNT) : 1;
	localparam int IDX_W  = $clog2(FINGER_COUNT + 1);
	localparam int FIX_W  = 24;
	localparam int CFG_W  = 23;
	// |scale * delta| * 2^FRACTION_BITS
	localparam int NUM_W  = 8 + 17 + FRACTION_BITS;
	localparam int DEN_W  = 32;

	localparam logic [1:0] CMD_DOWN = 2'd0;
	localparam logic [1:0] CMD_MOVE = 2'd1;
	localparam logic [1:0] CMD_LIFT = 2'd2;
	localparam logic [1:0] CMD_TICK = 2'd3;

	localparam logic [1:0] EV_DOWN = 2'd0;
	localparam logic [1:0] EV_MOVE = 2'd1;
	localparam logic [1:0] EV_LIFT = 2'd2;
	localparam logic [1:0] EV_HALT = 2'd3;

	localparam logic [1:0] CFG_VELOCITY_SCALE = 2'd0;
	localparam logic [1:0] CFG_DECAY_SINGLE   = 2'd1;
	localparam logic [1:0] CFG_DECAY_MULTI    = 2'd2;
	localparam logic [1:0] CFG_STOP_THRESHOLD = 2'd3;

	localparam logic signed [FIX_W:0] S24_MAX = 25'sd8388607;
	localparam logic signed [FIX_W:0] S24_MIN = -25'sd8388608;

	// one finger record, one memory word
	typedef struct packed {
		logic signed [15:0]      last_x;
		logic signed [15:0]      last_y;
		logic [31:0]             last_t;
		logic signed [15:0]      prior_x;
		logic signed [15:0]      prior_y;
		logic [31:0]             prior_t;
		logic signed [FIX_W-1:0] pos_x;
		logic signed [FIX_W-1:0] pos_y;
		logic signed [FIX_W-1:0] spd_x;
		logic signed [FIX_W-1:0] spd_y;
		logic [31:0]             start_t;
	} ent_t;

	typedef struct packed {
		logic              rd;
		logic              wr;
		logic [ADDR_W-1:0] addr;
	} mem_req_t;

	function automatic logic [FIX_W-1:0] mag24(input logic signed [FIX_W-1:0] v);
		logic signed [FIX_W:0] w;
		w = {v[FIX_W-1], v};
		return v[FIX_W-1] ? FIX_W'(-w) : FIX_W'(w);
	endfunction

	function automatic logic signed [FIX_W-1:0] sat24(input logic signed [FIX_W:0] v);
		if (v > S24_MAX) return S24_MAX[FIX_W-1:0];
		if (v < S24_MIN) return S24_MIN[FIX_W-1:0];
		return v[FIX_W-1:0];
	endfunction

	function automatic logic signed [FIX_W-1:0] to_fixed(input logic signed [15:0] px);
		logic signed [16+FRACTION_BITS-1:0] w;
		logic signed [FIX_W:0]              c;
		w = {px, {FRACTION_BITS{1'b0}}};
		if (16 + FRACTION_BITS > FIX_W + 1) begin
			if (w > (16+FRACTION_BITS)'(S24_MAX)) return S24_MAX[FIX_W-1:0];
			if (w < (16+FRACTION_BITS)'(S24_MIN)) return S24_MIN[FIX_W-1:0];
			return FIX_W'(w);
		end
		c = (FIX_W+1)'(w);
		return sat24(c);
	endfunction

	// whole pixels, toward zero, saturated to 16 bits
	function automatic logic [15:0] pixel(input logic signed [FIX_W-1:0] pos);
		logic [FIX_W-1:0] m;
		m = mag24(pos) >> FRACTION_BITS;
		if (pos[FIX_W-1]) begin
			if (m > FIX_W'(32768)) return 16'h8000;
			return 16'(-m);
		end
		if (m > FIX_W'(32767)) return 16'h7fff;
		return m[15:0];
	endfunction

	function automatic logic signed [FIX_W-1:0] decay(input logic signed [FIX_W-1:0] s,
			input logic [7:0] f);
		logic [FIX_W+7:0] p;
		logic [FIX_W-1:0] m;
		p = mag24(s) * f;
		m = p[FIX_W+7:8];
		return s[FIX_W-1] ? FIX_W'(-m) : FIX_W'(m);
	endfunction

	// signed quotient magnitude to a saturated 24-bit speed
	function automatic logic signed [FIX_W-1:0] sat_speed(input logic neg,
			input logic [NUM_W-1:0] q);
		if (neg) begin
			if (q > NUM_W'(8388608)) return S24_MIN[FIX_W-1:0];
			return FIX_W'(-q);
		end
		if (q > NUM_W'(8388607)) return S24_MAX[FIX_W-1:0];
		return FIX_W'(q);
	endfunction

endpackage

>>> hdl/ifg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifg_if
// Valid/ready channels: touch/tick items in, gesture events out.
// ----------------------------------------------------------------------------
interface ifg_item_if import ifg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [3:0]         finger;
	logic signed [15:0] touch_x;
	logic signed [15:0] touch_y;
	logic [31:0]        touch_time;
	logic [31:0]        now_time;
	logic [3:0]         fingers_pressed;

	modport source(output valid, cmd, finger, touch_x, touch_y, touch_time, now_time,
		fingers_pressed, input ready);
	modport sink(input valid, cmd, finger, touch_x, touch_y, touch_time, now_time,
		fingers_pressed, output ready);
endinterface

interface ifg_event_if import ifg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         event_kind;
	logic [3:0]         event_finger;
	logic signed [15:0] event_x;
	logic signed [15:0] event_y;
	logic [31:0]        event_time;
	logic               last_of_run;

	modport source(output valid, event_kind, event_finger, event_x, event_y, event_time,
		last_of_run, input ready);
	modport sink(input valid, event_kind, event_finger, event_x, event_y, event_time,
		last_of_run, output ready);
endinterface

>>> hdl/ifg_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifg_mem
// Finger record store, one word per finger, registered read.
// ----------------------------------------------------------------------------
module ifg_mem import ifg_pkg::*; (
	input  logic     clk,
	input  mem_req_t req,
	input  ent_t     wdata,
	output ent_t     rdata
);
	ent_t mem [FINGER_COUNT];

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= wdata;
		end
		if (req.rd) begin
			rdata <= mem[req.addr];
		end
	end
endmodule

>>> hdl/ifg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ifg_div import ifg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic [NUM_W-1:0] quotient,
	output logic             done
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] dvd_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   sh;
	logic             fits;

	assign sh   = {rem_q, dvd_q[NUM_W-1]};
	assign fits = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(sh - {1'b0, den_q}) : sh[DEN_W-1:0];
			dvd_q <= {dvd_q[NUM_W-2:0], fits};
		end
	end

	assign quotient = dvd_q;
endmodule

>>> hdl/inertial_fling_glide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inertial_fling_glide
// Per-finger touch inertia engine with exponentially decaying glide.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      word
//  item     in   valid/ready    cmd, finger, touch xy/time, now, pressed
//  result   out  valid/ready    event kind, finger, xy, time, last_of_run
//  cfg      in   cfg_we only    cfg_index, cfg_data
//
//  Down/move: read the record, write it back with the event. Lift: read the
//  record, divide once per axis (shared divider), write it back. Tick: walk
//  every finger slot, reading, stepping and writing back each gliding finger;
//  a down during a glide adds the same walk (lift words, no write) plus a halt word.
//  Reset clears the gliding flags; record contents are unknown until written.
//  A stalled result holds the sequencer in the state that emits (EMIT, HALT, EXEC).
// ----------------------------------------------------------------------------
module inertial_fling_glide import ifg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ifg_item_if.sink          item,
	ifg_event_if.source       result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);
	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_SCAN = 10'b0000000010,
		S_CALC = 10'b0000000100,
		S_EMIT = 10'b0000001000,
		S_HALT = 10'b0000010000,
		S_RD   = 10'b0000100000,
		S_EXEC = 10'b0001000000,
		S_DIVX = 10'b0010000000,
		S_DIVY = 10'b0100000000,
		S_WB   = 10'b1000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [7:0]       scale_q, dec_single_q, dec_multi_q;
	logic [CFG_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q      <= 8'd40;
			dec_single_q <= 8'd230;
			dec_multi_q  <= 8'd128;
			thr_q        <= CFG_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VELOCITY_SCALE: scale_q      <= cfg_data[7:0];
				CFG_DECAY_SINGLE:   dec_single_q <= cfg_data[7:0];
				CFG_DECAY_MULTI:    dec_multi_q  <= cfg_data[7:0];
				CFG_STOP_THRESHOLD: thr_q        <= cfg_data;
			endcase
		end
	end

	// latched item
	logic [1:0]         cmd_q;
	logic [3:0]         fg_q;
	logic signed [15:0] x_q, y_q;
	logic [31:0]        tt_q, now_q;
	logic [3:0]         pressed_q;

	logic [FINGER_COUNT-1:0] gliding_q;
	logic                    any_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    emitted_q;

	// record store
	mem_req_t mreq;
	ent_t     wdata, rdata, ent_q;

	ifg_mem u_mem (.clk(clk), .req(mreq), .wdata(wdata), .rdata(rdata));

	// divider, shared by both axes
	logic             div_start, div_done;
	logic [NUM_W-1:0] div_dvd, div_quo;
	logic [31:0]      dt_q;
	logic [DEN_W-1:0] div_den;
	logic signed [16:0] dx_q, dy_q;

	// x divide starts straight from the record read, y from the saved dt
	assign div_den = (state_q == S_EXEC) ? (tt_q - rdata.prior_t) : dt_q;

	ifg_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(div_den), .quotient(div_quo), .done(div_done)
	);

	// output register
	logic out_free, emit;
	logic [1:0]         ev_kind;
	logic [3:0]         ev_fg;
	logic [15:0]        ev_x, ev_y;
	logic [31:0]        ev_t;
	logic               ev_last;

	assign out_free   = !result.valid || result.ready;
	assign item.ready = (state_q == S_IDLE);

	wire accept = item.valid && item.ready;
	wire [ADDR_W-1:0] idx_a = idx_q[ADDR_W-1:0];
	wire [ADDR_W-1:0] fg_a  = fg_q[ADDR_W-1:0];
	wire scan_end = (idx_q == IDX_W'(FINGER_COUNT));
	wire is_tick  = (cmd_q == CMD_TICK);

	// glide step, first half: position and decayed speed
	logic                    act_x_q, act_y_q;
	logic signed [FIX_W-1:0] npx_q, npy_q, nsx_q, nsy_q;
	logic [7:0]              fac;
	assign fac = (pressed_q <= 4'd1) ? dec_single_q : dec_multi_q;

	wire act_x = mag24(rdata.spd_x) > FIX_W'(thr_q);
	wire act_y = mag24(rdata.spd_y) > FIX_W'(thr_q);

	always_ff @(posedge clk) begin
		if (state_q == S_CALC) begin
			act_x_q <= act_x;
			act_y_q <= act_y;
			npx_q   <= act_x ? sat24((FIX_W+1)'(rdata.pos_x) + (FIX_W+1)'(rdata.spd_x))
				: rdata.pos_x;
			npy_q   <= act_y ? sat24((FIX_W+1)'(rdata.pos_y) + (FIX_W+1)'(rdata.spd_y))
				: rdata.pos_y;
			nsx_q   <= act_x ? decay(rdata.spd_x, fac) : rdata.spd_x;
			nsy_q   <= act_y ? decay(rdata.spd_y, fac) : rdata.spd_y;
		end
	end

	// second half: still moving, and whether any later finger still glides
	wire go = (act_x_q && (mag24(nsx_q) > FIX_W'(thr_q)))
		|| (act_y_q && (mag24(nsy_q) > FIX_W'(thr_q)));
	wire [31:0] glide_t = ent_q.last_t + (now_q - ent_q.start_t);

	logic [FINGER_COUNT-1:0] above;
	always_comb begin
		for (int j = 0; j < FINGER_COUNT; j++) begin
			above[j] = gliding_q[j] && (IDX_W'(j) > idx_q);
		end
	end

	// lift: velocity numerator per axis
	logic [16:0] dmag;
	logic [24:0] prod;
	always_comb begin
		logic signed [16:0] d;
		d       = (state_q == S_EXEC) ? 17'(x_q - rdata.prior_x) : dy_q;
		dmag    = d[16] ? 17'(-d) : 17'(d);
		prod    = scale_q * dmag;
		div_dvd = {prod, {FRACTION_BITS{1'b0}}};
	end

	// sequencer outputs
	always_comb begin
		mreq      = '0;
		mreq.addr = fg_a;
		wdata     = rdata;
		emit      = 1'b0;
		ev_kind   = EV_DOWN;
		ev_fg     = fg_q;
		ev_x      = x_q;
		ev_y      = y_q;
		ev_t      = tt_q;
		ev_last   = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			S_SCAN: begin
				mreq.addr = idx_a;
				mreq.rd   = !scan_end && gliding_q[idx_a];
			end
			S_EMIT: begin
				mreq.addr = idx_a;
				emit      = out_free;
				ev_fg     = 4'(idx_q);
				ev_t      = glide_t;
				if (is_tick) begin
					ev_kind     = go ? EV_MOVE : EV_LIFT;
					ev_x        = pixel(npx_q);
					ev_y        = pixel(npy_q);
					ev_last     = (above == '0);
					wdata       = ent_q;
					wdata.pos_x = npx_q;
					wdata.pos_y = npy_q;
					wdata.spd_x = nsx_q;
					wdata.spd_y = nsy_q;
					mreq.wr     = out_free;
				end else begin
					ev_kind = EV_LIFT;
					ev_x    = pixel(ent_q.pos_x);
					ev_y    = pixel(ent_q.pos_y);
				end
			end
			S_HALT: begin
				emit    = out_free;
				ev_kind = EV_HALT;
				ev_fg   = '0;
				ev_x    = '0;
				ev_y    = '0;
				ev_t    = '0;
			end
			S_RD: begin
				mreq.rd = 1'b1;
			end
			S_EXEC: begin
				wdata.last_x = x_q;
				wdata.last_y = y_q;
				wdata.last_t = tt_q;
				wdata.pos_x  = to_fixed(x_q);
				wdata.pos_y  = to_fixed(y_q);
				if (cmd_q == CMD_DOWN) begin
					wdata.prior_x = x_q;
					wdata.prior_y = y_q;
					wdata.prior_t = tt_q;
				end else begin
					wdata.prior_x = rdata.last_x;
					wdata.prior_y = rdata.last_y;
					wdata.prior_t = rdata.last_t;
				end
				if (cmd_q == CMD_LIFT) begin
					div_start = 1'b1;
				end else begin
					emit    = out_free;
					mreq.wr = out_free;
					ev_kind = (cmd_q == CMD_DOWN) ? EV_DOWN : EV_MOVE;
					ev_last = 1'b1;
				end
			end
			S_DIVX: begin
				div_start = div_done;
			end
			S_WB: begin
				wdata   = ent_q;
				mreq.wr = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			gliding_q <= '0;
			any_q     <= 1'b0;
			idx_q     <= '0;
			emitted_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q     <= '0;
						emitted_q <= 1'b0;
						if (item.cmd == CMD_TICK) begin
							if (any_q) state_q <= S_SCAN;
						end else if ({1'b0, item.finger} < 5'(FINGER_COUNT)) begin
							state_q <= (item.cmd == CMD_DOWN && any_q) ? S_SCAN : S_RD;
						end
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						if (is_tick) begin
							if (!emitted_q) any_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_HALT;
						end
					end else if (gliding_q[idx_a]) begin
						state_q <= S_CALC;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_CALC: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						if (is_tick) gliding_q[idx_a] <= go;
						emitted_q <= 1'b1;
						idx_q     <= idx_q + 1'b1;
						state_q   <= S_SCAN;
					end
				end
				S_HALT: begin
					if (out_free) begin
						gliding_q <= '0;
						any_q     <= 1'b0;
						state_q   <= S_RD;
					end
				end
				S_RD: state_q <= S_EXEC;
				S_EXEC: begin
					if (cmd_q == CMD_LIFT) begin
						state_q <= S_DIVX;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DIVX: if (div_done) state_q <= S_DIVY;
				S_DIVY: if (div_done) state_q <= S_WB;
				S_WB: begin
					gliding_q[fg_a] <= 1'b1;
					any_q           <= 1'b1;
					state_q         <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload, glide record copy and lift working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= item.cmd;
			fg_q      <= item.finger;
			x_q       <= item.touch_x;
			y_q       <= item.touch_y;
			tt_q      <= item.touch_time;
			now_q     <= item.now_time;
			pressed_q <= item.fingers_pressed;
		end
		if (state_q == S_CALC) begin
			ent_q <= rdata;
		end
		if (state_q == S_EXEC && cmd_q == CMD_LIFT) begin
			ent_q         <= rdata;
			ent_q.last_x  <= x_q;
			ent_q.last_y  <= y_q;
			ent_q.last_t  <= tt_q;
			ent_q.start_t <= now_q;
			dx_q          <= 17'(x_q - rdata.prior_x);
			dy_q          <= 17'(y_q - rdata.prior_y);
			dt_q          <= tt_q - rdata.prior_t;
		end
		// zero elapsed time gives zero speed
		if (state_q == S_DIVX && div_done) begin
			ent_q.spd_x <= (dt_q == '0) ? '0 : sat_speed(dx_q[16], div_quo);
		end
		if (state_q == S_DIVY && div_done) begin
			ent_q.spd_y <= (dt_q == '0) ? '0 : sat_speed(dy_q[16], div_quo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (emit) begin
			result.valid <= 1'b1;
		end else if (result.ready) begin
			result.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result.event_kind   <= ev_kind;
			result.event_finger <= ev_fg;
			result.event_x      <= ev_x;
			result.event_y      <= ev_y;
			result.event_time   <= ev_t;
			result.last_of_run  <= ev_last;
		end
	end

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.cmd != CMD_TICK && ({1'b0, item.finger} < 5'(FINGER_COUNT))
		|=> !item.ready)
		else $error("item taken while sequencer busy");
	a_glide_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!any_q |-> (gliding_q == '0))
		else $error("finger gliding with glide off");
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIVX || state_q == S_DIVY))
		else $error("divider result outside lift");
	a_halt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		emit && ev_kind == EV_HALT |-> ev_fg == '0 && ev_t == '0 && !ev_last)
		else $error("halt word carries payload");
endmodule
